// ===== hw/rtl/glc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glc_pkg: shared types and constants of the glyph LRU cache
// Field widths, command and status codes, register reset value.
// ----------------------------------------------------------------------------
package glc_pkg;

  localparam int ENTRIES_DEF = 64;

  localparam int CFG_W     = 7;
  localparam logic [CFG_W-1:0] CAP_RESET = 7'd64;

  localparam int ID_W      = 8;
  localparam int SIZE_W    = 8;
  localparam int WEIGHT_W  = 10;
  localparam int CHAR_W    = 21;
  localparam int KEY_W     = ID_W + SIZE_W + WEIGHT_W + CHAR_W;
  localparam int ADV_RAW_W = 17;
  localparam int ADV_SHIFT = 6;
  localparam int ADV_W     = ADV_RAW_W - ADV_SHIFT;
  localparam int BEAR_W    = 11;
  localparam int DIM_W     = 10;
  localparam int MET_W     = 2 * ADV_W + 2 * BEAR_W + 2 * DIM_W;
  localparam int CNT_W     = 32;

  localparam int IN_BITS   = KEY_W + 2 * ADV_RAW_W + 2 * BEAR_W + 2 * DIM_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int IN_USER_W = 2;
  localparam int OUT_USER_W = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_CLEAR  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_HIT          = 2'd0,
    ST_INSERTED     = 2'd1,
    ST_NOT_INSERTED = 2'd2,
    ST_CLEARED      = 2'd3
  } status_t;

  // outcome of one lookup in the directory
  typedef struct packed {
    logic hit;
    logic insert;
  } lookup_t;

endpackage

// ===== hw/rtl/glyph_lru_cache_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_lru_cache_core: fully associative LRU cache of glyph metrics
//
// Input beats carry a command and a glyph key with optional fill metrics;
// every input beat yields exactly one result beat with status, slot,
// metrics, occupancy and the saturating hit and miss counters.
// Pipeline: an accepted beat passes the input register, the lookup/update
// stage and the output register in that order.
// Throughput: one beat per cycle while the output beat is taken; the key
// compare over all entries and the rank update finish in the lookup stage,
// and the metrics RAM is read or written at most once per beat.
// Reset: all entries invalid, counters zero, capacity register 64.
// Stall: while the output beat is not taken, the pipeline holds and
// in_tready drops; nothing is lost or repeated.
// cfg_wr_en writes capacity_limit; write it only while the block is idle.
// ----------------------------------------------------------------------------
module glyph_lru_cache_core #(
  parameter int ENTRIES = glc_pkg::ENTRIES_DEF,
  parameter int IW      = $clog2(ENTRIES),
  parameter int CW      = $clog2(ENTRIES + 1),
  parameter int OUT_DATA_W = ((IW + CW + glc_pkg::MET_W + 2 * glc_pkg::CNT_W + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [glc_pkg::CFG_W-1:0]        cfg_wr_data,   // capacity_limit
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // font_id, font_size, font_weight, char_code, advance_x_raw, advance_y_raw,
  // bearing_x, bearing_y, glyph_width, glyph_height
  input  logic [glc_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic [glc_pkg::IN_USER_W-1:0]    in_tuser,      // command, fill_valid
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // slot, out_advance_x, out_advance_y, out_bearing_x, out_bearing_y,
  // out_width, out_height, entries_held, hit_total, miss_total
  output logic [OUT_DATA_W-1:0]            out_tdata,
  output logic [glc_pkg::OUT_USER_W-1:0]   out_tuser      // status
);

  localparam int KW = glc_pkg::KEY_W;
  localparam int AR = glc_pkg::ADV_RAW_W;
  localparam int BW = glc_pkg::BEAR_W;
  localparam int DW = glc_pkg::DIM_W;
  localparam int MW = glc_pkg::MET_W;
  localparam int NW = glc_pkg::CNT_W;
  localparam int PAD_W = OUT_DATA_W - (IW + CW + MW + 2 * NW);

  localparam int OFS_ADVX = KW;
  localparam int OFS_ADVY = OFS_ADVX + AR;
  localparam int OFS_BX   = OFS_ADVY + AR;
  localparam int OFS_BY   = OFS_BX + BW;
  localparam int OFS_W    = OFS_BY + BW;
  localparam int OFS_H    = OFS_W + DW;

  logic [glc_pkg::CFG_W-1:0]     cap_r;
  logic [CW-1:0]                 cap_eff;

  logic                          adv;
  logic                          go;

  logic                          v1_r;
  logic [glc_pkg::IN_DATA_W-1:0] data1_r;
  logic [glc_pkg::IN_USER_W-1:0] user1_r;

  logic                          clear1;
  logic                          fill1;
  logic [MW-1:0]                 met1;
  glc_pkg::lookup_t              look;
  logic [IW-1:0]                 idx;
  logic [CW-1:0]                 occ_after;
  glc_pkg::status_t              status1;

  logic [NW-1:0]                 hit_cnt_r;
  logic [NW-1:0]                 hit_cnt_nxt;
  logic [NW-1:0]                 miss_cnt_r;
  logic [NW-1:0]                 miss_cnt_nxt;

  logic                          v2_r;
  glc_pkg::status_t              status2_r;
  logic [IW-1:0]                 slot2_r;
  logic                          use_ram2_r;
  logic [MW-1:0]                 met2_r;
  logic [CW-1:0]                 held2_r;
  logic [NW-1:0]                 hit2_r;
  logic [NW-1:0]                 miss2_r;

  logic [MW-1:0]                 ram_rdata;
  logic [MW-1:0]                 met_out;

  logic                          vout_r;
  glc_pkg::status_t              status_out_r;
  logic [OUT_DATA_W-1:0]         data_out_r;
  logic [OUT_DATA_W-1:0]         data_out_nxt;

  // capacity register and its clamp to 1..ENTRIES
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= glc_pkg::CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CW'(1);
    end else if (32'(cap_r) > 32'(ENTRIES)) begin
      cap_eff = CW'(ENTRIES);
    end else begin
      cap_eff = CW'(cap_r);
    end
  end

  // whole pipeline moves when the output register is free
  assign adv       = !vout_r || out_tready;
  assign in_tready = adv;
  assign go        = adv && v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_tvalid) begin
      data1_r <= in_tdata;
      user1_r <= in_tuser;
    end
  end

  assign clear1 = (glc_pkg::cmd_t'(user1_r[0]) == glc_pkg::CMD_CLEAR);
  assign fill1  = user1_r[1];

  // advances drop the six fraction bits of 11.6
  assign met1 = {data1_r[OFS_H +: DW],
                 data1_r[OFS_W +: DW],
                 data1_r[OFS_BY +: BW],
                 data1_r[OFS_BX +: BW],
                 data1_r[OFS_ADVY + glc_pkg::ADV_SHIFT +: glc_pkg::ADV_W],
                 data1_r[OFS_ADVX + glc_pkg::ADV_SHIFT +: glc_pkg::ADV_W]};

  glc_lru_dir #(
    .ENTRIES (ENTRIES),
    .IW      (IW),
    .CW      (CW)
  ) u_dir (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .clear     (clear1),
    .fill      (fill1),
    .key       (data1_r[KW-1:0]),
    .cap       (cap_eff),
    .look      (look),
    .idx       (idx),
    .occ_after (occ_after)
  );

  glc_ram #(
    .WIDTH (MW),
    .DEPTH (ENTRIES)
  ) u_met_ram (
    .clk   (clk),
    .we    (go && look.insert),
    .waddr (idx),
    .wdata (met1),
    .re    (go && look.hit),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  always_comb begin
    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    if (clear1) begin
      status1      = glc_pkg::ST_CLEARED;
      hit_cnt_nxt  = '0;
      miss_cnt_nxt = '0;
    end else if (look.hit) begin
      status1 = glc_pkg::ST_HIT;
      if (hit_cnt_r != glc_pkg::CNT_MAX) begin
        hit_cnt_nxt = hit_cnt_r + 1'b1;
      end
    end else begin
      status1 = look.insert ? glc_pkg::ST_INSERTED : glc_pkg::ST_NOT_INSERTED;
      if (miss_cnt_r != glc_pkg::CNT_MAX) begin
        miss_cnt_nxt = miss_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r  <= '0;
      miss_cnt_r <= '0;
      v2_r       <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
      if (v1_r) begin
        hit_cnt_r  <= hit_cnt_nxt;
        miss_cnt_r <= miss_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      status2_r  <= status1;
      slot2_r    <= idx;
      use_ram2_r <= look.hit;
      met2_r     <= look.insert ? met1 : '0;
      held2_r    <= occ_after;
      hit2_r     <= hit_cnt_nxt;
      miss2_r    <= miss_cnt_nxt;
    end
  end

  // hits take metrics from the RAM, read during the lookup stage
  assign met_out      = use_ram2_r ? ram_rdata : met2_r;
  assign data_out_nxt = {{PAD_W{1'b0}}, miss2_r, hit2_r, held2_r, met_out, slot2_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vout_r <= 1'b0;
    end else if (adv) begin
      vout_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v2_r) begin
      status_out_r <= status2_r;
      data_out_r   <= data_out_nxt;
    end
  end

  assign out_tvalid = vout_r;
  assign out_tdata  = data_out_r;
  assign out_tuser  = status_out_r;

  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    go && clear1 |=> (hit_cnt_r == '0) && (miss_cnt_r == '0))
    else $error("clear left a counter nonzero");

  a_ram_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && use_ram2_r |-> (status2_r == glc_pkg::ST_HIT))
    else $error("RAM metrics selected for a non-hit");

  a_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && ((status2_r == glc_pkg::ST_NOT_INSERTED) || (status2_r == glc_pkg::ST_CLEARED))
    |-> (slot2_r == '0) && (met2_r == '0))
    else $error("slot or metrics set without an entry");

endmodule

// ===== hw/rtl/glc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module glc_ram #(
  parameter int WIDTH = glc_pkg::MET_W,
  parameter int DEPTH = glc_pkg::ENTRIES_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/glc_lru_dir.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glc_lru_dir: tag directory and recency order of the glyph LRU cache
// Parallel key compare, per-entry rank update, eviction and free-slot pick.
// ----------------------------------------------------------------------------
module glc_lru_dir #(
  parameter int ENTRIES = glc_pkg::ENTRIES_DEF,
  parameter int IW      = $clog2(ENTRIES),
  parameter int CW      = $clog2(ENTRIES + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     go,
  input  logic                     clear,
  input  logic                     fill,
  input  logic [glc_pkg::KEY_W-1:0] key,
  input  logic [CW-1:0]            cap,
  output glc_pkg::lookup_t         look,
  output logic [IW-1:0]            idx,
  output logic [CW-1:0]            occ_after
);

  logic [ENTRIES-1:0]        valid_r;
  logic [ENTRIES-1:0]        valid_nxt;
  logic [ENTRIES-1:0]        match;
  logic [ENTRIES-1:0]        keep;
  logic [ENTRIES-1:0]        free;
  logic [ENTRIES-1:0]        free_first;
  logic [glc_pkg::KEY_W-1:0] key_r [ENTRIES];
  logic [IW-1:0]             rank_r [ENTRIES];
  logic [IW-1:0]             rank_nxt [ENTRIES];
  logic [CW:0]               rank_p1 [ENTRIES];
  logic [IW-1:0]             hit_rank;
  logic [IW-1:0]             hit_idx;
  logic [IW-1:0]             free_idx;
  logic [CW-1:0]             occ_r;
  logic [CW-1:0]             occ_nxt;
  logic                      hit;
  logic                      insert;

  // compare, eviction check; match is one-hot, so encode by OR
  always_comb begin
    hit_rank = '0;
    hit_idx  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]   = valid_r[i] && (key_r[i] == key);
      rank_p1[i] = (CW + 1)'(rank_r[i]) + 1'b1;
      keep[i]    = valid_r[i] && (rank_p1[i] < {1'b0, cap});
      if (match[i]) begin
        hit_rank = hit_rank | rank_r[i];
        hit_idx  = hit_idx | IW'(i);
      end
    end
  end

  // lowest free slot after eviction
  always_comb begin
    free       = ~keep;
    free_first = free & (~free + 1'b1);
    free_idx   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (free_first[i]) begin
        free_idx = free_idx | IW'(i);
      end
    end
  end

  assign hit    = |match;
  assign insert = !clear && !hit && fill;

  always_comb begin
    look.hit    = !clear && hit;
    look.insert = insert;
    if (clear) begin
      idx = '0;
    end else if (hit) begin
      idx = hit_idx;
    end else if (insert) begin
      idx = free_idx;
    end else begin
      idx = '0;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    occ_nxt   = occ_r;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
    end
    if (clear) begin
      valid_nxt = '0;
      occ_nxt   = '0;
    end else if (hit) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_r[i] && (rank_r[i] < hit_rank)) begin
          rank_nxt[i] = rank_r[i] + 1'b1;
        end
        if (match[i]) begin
          rank_nxt[i] = '0;
        end
      end
    end else if (insert) begin
      valid_nxt = keep | free_first;
      for (int i = 0; i < ENTRIES; i++) begin
        if (keep[i]) begin
          rank_nxt[i] = rank_r[i] + 1'b1;
        end
        if (free_first[i]) begin
          rank_nxt[i] = '0;
        end
      end
      // ranks of valid entries are always 0..occ-1
      occ_nxt = (occ_r < cap) ? occ_r + 1'b1 : cap;
    end
  end

  assign occ_after = occ_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
    end else if (go) begin
      valid_r <= valid_nxt;
      occ_r   <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= rank_nxt[i];
        if (insert && free_first[i]) begin
          key_r[i] <= key;
        end
      end
    end
  end

  a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(occ_r))
    else $error("occupancy does not match valid entries");

  a_key_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match))
    else $error("key matches more than one entry");

  a_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    go && insert |-> (free != '0))
    else $error("insertion without a free slot");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the glyph LRU cache core
// A behavioral copy of the cache (keys, recency ranks, metrics, counters)
// predicts one result per accepted request beat; each result beat is checked
// field by field in order. Directed requests cover the field extremes and
// corner cases. Random phases with pooled keys then run under several
// capacity settings, with random gaps on the request side and random stalls
// on the result side in all but the last phase.
// ----------------------------------------------------------------------------
module tb_top;
  import glc_pkg::*;

  localparam int NSLOT = ENTRIES_DEF;
  localparam int OUT_DW = ((6 + 7 + MET_W + 2 * CNT_W + 7) / 8) * 8;
  localparam int STALL_LIMIT = 4000;
  localparam int POOL_N = 96;

  typedef struct packed {
    logic [10:0] adv_x;
    logic [10:0] adv_y;
    logic [10:0] bear_x;
    logic [10:0] bear_y;
    logic [9:0]  width;
    logic [9:0]  height;
  } glyph_metrics_t;

  typedef struct packed {
    status_t        status;
    logic [5:0]     slot;
    glyph_metrics_t met;
    logic [6:0]     held;
    logic [31:0]    hits;
    logic [31:0]    misses;
  } glyph_result_t;

  typedef struct packed {
    cmd_t        cmd;
    logic        fill;
    logic [46:0] key;      // font_id, font_size, font_weight, char_code (msb first)
    logic [16:0] adv_x_raw;
    logic [16:0] adv_y_raw;
    logic [10:0] bear_x;
    logic [10:0] bear_y;
    logic [9:0]  width;
    logic [9:0]  height;
  } glyph_req_t;

  class glyph_cache_scoreboard;
    logic [46:0]    tag[NSLOT];
    bit             live[NSLOT];
    int unsigned    recency[NSLOT];
    glyph_metrics_t stored[NSLOT];
    logic [31:0]    hits;
    logic [31:0]    misses;
    int unsigned    capacity;
    glyph_result_t  expected_q[$];
    int unsigned    mismatches;
    int unsigned    results_seen;

    function new();
      foreach (live[i]) live[i] = 1'b0;
      hits = '0;
      misses = '0;
      capacity = CAP_RESET;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function void set_capacity(logic [6:0] v);
      capacity = v;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_input(logic [IN_DATA_W-1:0] d, logic [IN_USER_W-1:0] u);
      glyph_result_t r;
      logic [46:0] k;
      int hit_idx;
      int unsigned cap_eff;
      int unsigned rk;
      int unsigned held;
      int i;
      r = '0;
      r.status = ST_CLEARED;
      if (cmd_t'(u[0]) == CMD_CLEAR) begin
        foreach (live[j]) live[j] = 1'b0;
        hits = '0;
        misses = '0;
      end else begin
        k = {d[7:0], d[15:8], d[25:16], d[46:26]};
        hit_idx = -1;
        for (i = 0; i < NSLOT; i++) begin
          if (live[i] && tag[i] == k) begin
            hit_idx = i;
            break;
          end
        end
        if (hit_idx >= 0) begin
          if (hits != CNT_MAX) hits++;
          rk = recency[hit_idx];
          for (i = 0; i < NSLOT; i++)
            if (live[i] && recency[i] < rk) recency[i]++;
          recency[hit_idx] = 0;
          r.status = ST_HIT;
          r.slot = hit_idx[5:0];
          r.met = stored[hit_idx];
        end else begin
          if (misses != CNT_MAX) misses++;
          if (u[1]) begin
            cap_eff = (capacity == 0) ? 1 : (capacity > NSLOT) ? NSLOT : capacity;
            // age everything; drop what falls off the end of the order
            for (i = 0; i < NSLOT; i++) begin
              if (live[i]) begin
                if (recency[i] + 1 >= cap_eff) live[i] = 1'b0;
                else recency[i]++;
              end
            end
            for (i = 0; i < NSLOT; i++)
              if (!live[i]) break;
            live[i] = 1'b1;
            tag[i] = k;
            recency[i] = 0;
            // whole pixels: drop the six fraction bits of the 11.6 advance
            stored[i].adv_x = d[63:53];
            stored[i].adv_y = d[80:70];
            stored[i].bear_x = d[91:81];
            stored[i].bear_y = d[102:92];
            stored[i].width = d[112:103];
            stored[i].height = d[122:113];
            r.status = ST_INSERTED;
            r.slot = i[5:0];
            r.met = stored[i];
          end else begin
            r.status = ST_NOT_INSERTED;
          end
        end
      end
      held = 0;
      foreach (live[j]) if (live[j]) held++;
      r.held = held[6:0];
      r.hits = hits;
      r.misses = misses;
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: %s expected 0x%0h, got 0x%0h", results_seen, name, want, got);
      end
    endfunction

    function void check_result(logic [OUT_DW-1:0] d, logic [OUT_USER_W-1:0] u);
      glyph_result_t e;
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: beat with nothing outstanding, data 0x%0h status %0d",
                   results_seen, d, u);
        return;
      end
      e = expected_q.pop_front();
      compare_field("status", e.status, u);
      compare_field("slot", e.slot, d[5:0]);
      compare_field("advance_x", e.met.adv_x, d[16:6]);
      compare_field("advance_y", e.met.adv_y, d[27:17]);
      compare_field("bearing_x", e.met.bear_x, d[38:28]);
      compare_field("bearing_y", e.met.bear_y, d[49:39]);
      compare_field("width", e.met.width, d[59:50]);
      compare_field("height", e.met.height, d[69:60]);
      compare_field("entries_held", e.held, d[76:70]);
      compare_field("hit_total", e.hits, d[108:77]);
      compare_field("miss_total", e.misses, d[140:109]);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]      cfg_wr_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DW-1:0]     out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  bit                    tx_gaps = 1'b1;
  bit                    rx_stalls = 1'b1;
  int unsigned           quiet_cycles = 0;
  logic [46:0]           key_pool[POOL_N];
  glyph_cache_scoreboard sb = new();

  glyph_lru_cache_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // check results before noting requests so a stray beat cannot pair with a new one
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
      if (in_tvalid && in_tready) sb.note_input(in_tdata, in_tuser);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: ready most of the time, stalled in short random bursts
  initial begin
    @(posedge clk);
    forever begin
      if (rx_stalls && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  function automatic glyph_req_t mk_req(cmd_t c, logic f, logic [46:0] k,
                                        logic [16:0] ax, logic [16:0] ay,
                                        logic [10:0] bx, logic [10:0] by,
                                        logic [9:0] w, logic [9:0] h);
    glyph_req_t q;
    q.cmd = c;
    q.fill = f;
    q.key = k;
    q.adv_x_raw = ax;
    q.adv_y_raw = ay;
    q.bear_x = bx;
    q.bear_y = by;
    q.width = w;
    q.height = h;
    return q;
  endfunction

  function automatic glyph_req_t random_req(int unsigned span, bit clears);
    glyph_req_t q;
    q.cmd = (clears && $urandom_range(0, 39) == 0) ? CMD_CLEAR : CMD_LOOKUP;
    q.fill = ($urandom_range(0, 9) < 7);
    if ($urandom_range(0, 99) < 15) q.key = 47'({$urandom(), $urandom()});
    else q.key = key_pool[$urandom_range(0, span - 1)];
    q.adv_x_raw = 17'($urandom());
    q.adv_y_raw = 17'($urandom());
    q.bear_x = 11'($urandom());
    q.bear_y = 11'($urandom());
    q.width = 10'($urandom());
    q.height = 10'($urandom());
    return q;
  endfunction

  task automatic send_glyph(glyph_req_t q);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= {q.fill, q.cmd};
    in_tdata <= {5'd0, q.height, q.width, q.bear_y, q.bear_x, q.adv_y_raw, q.adv_x_raw,
                 q.key[20:0], q.key[30:21], q.key[38:31], q.key[46:39]};
    do @(posedge clk); while (!in_tready);
  endtask

  // hold until every outstanding result has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    // let the monitor note the beat taken at the last edge first
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [6:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_capacity(v);
    @(posedge clk);
  endtask

  task automatic run_phase(int unsigned n, int unsigned span, bit clears);
    repeat (n) send_glyph(random_req(span, clears));
    in_tvalid <= 1'b0;
  endtask

  initial begin
    glyph_req_t noise;
    logic [46:0] k_ones;
    for (int i = 0; i < POOL_N; i++) key_pool[i] = 47'({$urandom(), $urandom()});
    k_ones = '1;
    key_pool[0] = '0;
    key_pool[1] = k_ones;
    noise = random_req(POOL_N, 1'b0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, hit with fill, clear, key fields one at a time
    send_glyph(mk_req(CMD_LOOKUP, 1'b0, '0, '0, '0, '0, '0, '0, '0));
    // advance -65536 / +65535, bearings -1024 / +1023
    send_glyph(mk_req(CMD_LOOKUP, 1'b1, '0, 17'h10000, 17'h0FFFF, 11'h400, 11'h3FF,
                      10'h3FF, 10'h000));
    send_glyph(mk_req(CMD_LOOKUP, 1'b1, '0, 17'h00040, 17'h1FFC0, 11'h001, 11'h7FF,
                      10'h155, 10'h2AA));
    send_glyph(mk_req(CMD_LOOKUP, 1'b1, k_ones, 17'h0FFFF, 17'h10000, 11'h3FF, 11'h400,
                      10'h000, 10'h3FF));
    send_glyph(mk_req(CMD_LOOKUP, 1'b0, k_ones, '0, '0, '0, '0, '0, '0));
    send_glyph(mk_req(CMD_LOOKUP, 1'b0, '0, '0, '0, '0, '0, '0, '0));
    // small advances around the fraction boundary: -1, 63, -64, 64
    send_glyph(mk_req(CMD_LOOKUP, 1'b1, key_pool[2], 17'h1FFFF, 17'h0003F, 11'h000, 11'h000,
                      10'h001, 10'h001));
    send_glyph(mk_req(CMD_LOOKUP, 1'b1, key_pool[3], 17'h1FFC0, 17'h00040, 11'h2AA, 11'h555,
                      10'h2AA, 10'h155));
    send_glyph(mk_req(CMD_CLEAR, 1'b1, k_ones, noise.adv_x_raw, noise.adv_y_raw,
                      noise.bear_x, noise.bear_y, noise.width, noise.height));
    send_glyph(mk_req(CMD_LOOKUP, 1'b0, '0, '0, '0, '0, '0, '0, '0));
    send_glyph(mk_req(CMD_LOOKUP, 1'b1, {8'hFF, 39'd0}, 17'h00A40, 17'h1F5C0, 11'h010, 11'h7F0,
                      10'h020, 10'h030));
    send_glyph(mk_req(CMD_LOOKUP, 1'b1, {8'd0, 8'hFF, 31'd0}, 17'h00080, 17'h00000, 11'h001,
                      11'h002, 10'h003, 10'h004));
    send_glyph(mk_req(CMD_LOOKUP, 1'b1, {16'd0, 10'h3FF, 21'd0}, 17'h000C0, 17'h00000, 11'h005,
                      11'h006, 10'h007, 10'h008));
    // highest code point in range, then the raw 21-bit maximum
    send_glyph(mk_req(CMD_LOOKUP, 1'b1, {26'd0, 21'd1114111}, 17'h00100, 17'h00000, 11'h009,
                      11'h00A, 10'h00B, 10'h00C));
    send_glyph(mk_req(CMD_LOOKUP, 1'b1, {26'd0, 21'h1FFFFF}, 17'h00140, 17'h00000, 11'h00D,
                      11'h00E, 10'h00F, 10'h010));
    send_glyph(mk_req(CMD_LOOKUP, 1'b1, {8'hFF, 39'd0}, '0, '0, '0, '0, '0, '0));
    send_glyph(mk_req(CMD_LOOKUP, 1'b0, {26'd0, 21'd1114111}, '0, '0, '0, '0, '0, '0));
    send_glyph(mk_req(CMD_CLEAR, 1'b0, '0, '0, '0, '0, '0, '0, '0));
    in_tvalid <= 1'b0;

    write_capacity(7'd64);
    run_phase(130, POOL_N, 1'b1);
    // capacity zero behaves as one
    write_capacity(7'd0);
    run_phase(60, 4, 1'b1);
    // above the entry count: eviction at the full table
    write_capacity(7'd127);
    run_phase(150, POOL_N, 1'b0);
    // lowered below occupancy: old entries linger until the next fill
    write_capacity(7'd3);
    run_phase(80, 10, 1'b0);
    write_capacity(7'd1);
    run_phase(40, 3, 1'b1);
    write_capacity(7'd64);
    tx_gaps = 1'b0;
    rx_stalls = 1'b0;
    run_phase(170, POOL_N, 1'b1);

    drain();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/glc_pkg.sv
hw/rtl/glc_ram.sv
hw/rtl/glc_lru_dir.sv
hw/rtl/glyph_lru_cache_core.sv
tb/tb_top.sv
